// File: src/escape_coded_spectrum_unpacker_unit_defines.svh
// Assertion macros for the escape-coded spectrum unpacker.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ESCAPE_CODED_SPECTRUM_UNPACKER_UNIT_DEFINES_SVH
`define ESCAPE_CODED_SPECTRUM_UNPACKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ecsu_pkg.sv
// Shared types and constants of the escape-coded spectrum unpacker.
// No dependencies.
package ecsu_pkg;

    localparam int TOTAL_W = 13;

    localparam logic [7:0] ESC_ZERO = 8'h81;
    localparam logic [7:0] ESC_RUN2 = 8'h82;
    localparam logic [7:0] ESC_RUN4 = 8'h84;
    localparam logic [7:0] LIT_MARK = 8'h80;
    localparam logic [1:0] TERM2    = 2'h2;
    localparam logic [3:0] TERM4    = 4'h8;

    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_AFTER81 = 6'b000010,
        MODE_AFTER82 = 6'b000100,
        MODE_AFTER84 = 6'b001000,
        MODE_RUN2    = 6'b010000,
        MODE_RUN4    = 6'b100000
    } ecsu_mode_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       stream_last;
    } ecsu_in_t;

    typedef struct packed {
        logic [7:0]         out_value;
        logic [7:0]         repeat_count;
        logic               last_of_item;
        logic               stream_done;
        logic               decode_error;
        logic [TOTAL_W-1:0] total_out;
    } ecsu_res_t;

    // Up to four results from one packed byte, slot 0 first.
    typedef ecsu_res_t [3:0] ecsu_batch_t;

endpackage

// File: src/escape_coded_spectrum_unpacker_unit.sv
// Escape-coded spectrum unpacker. Each transaction on the s_ side carries one byte of the
// packed stream and a flag for its final byte; each transaction on the m_ side carries one
// unpacked result (a value with a repeat count, the running total and end/error flags).
// A byte is held in an input register, decoded combinationally into up to four results,
// and these are issued from a result register one per cycle while m_ready is high. A
// byte holds the result register until its last result is taken, and a byte with no
// result passes without entering it; while the last result of a byte waits, the next
// byte is already taken and decoded. A result passes through the input register and
// then the result register. Zero runs come out as a single result with a repeat count.
// An error is sticky until the final byte of the stream, which always yields a result
// with stream_done set; after that byte the decoder starts afresh with a zero count.
`include "escape_coded_spectrum_unpacker_unit_defines.svh"

module escape_coded_spectrum_unpacker_unit import ecsu_pkg::*; #(
    parameter int CAPACITY = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ecsu_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ecsu_res_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                in_valid_reg;
    ecsu_in_t            in_data_reg;
    logic                take;
    logic                load_ok;
    logic                batch_valid;
    ecsu_batch_t         batch;
    logic [CW-1:0]       dec_count;

    // Input register: accept when empty or when the held byte advances this cycle.
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Decode the held byte and update mode, count and error state on advance.
    ecsu_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid_reg),
        .in_data     (in_data_reg),
        .load_ok     (load_ok),
        .take        (take),
        .batch_valid (batch_valid),
        .batch       (batch),
        .count_q     (dec_count)
    );

    // Hold the batch and issue its results in order.
    ecsu_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .batch_valid (batch_valid),
        .batch       (batch),
        .load_ok     (load_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // A batch issues without gaps once its first result is taken.
    `ECSU_ASSERT_NEXT(a_batch_no_gap, m_valid && m_ready && !m_data.last_of_item, m_valid, "batch interrupted before its final result")
    // The running count never passes the capacity.
    `ECSU_ASSERT_SAME(a_count_cap, 1'b1, 32'(dec_count) <= 32'(CAPACITY), "output count beyond capacity")
    // End and error notices only close a byte.
    `ECSU_ASSERT_SAME(a_flags_final, m_valid && (m_data.stream_done || m_data.decode_error), m_data.last_of_item, "end or error flag on a non-final result")

endmodule

// File: src/ecsu_decode.sv
// Decoder: mode, count and error state plus the single-pass decode of one byte.
// Depends on ecsu_pkg.
module ecsu_decode import ecsu_pkg::*; #(
    parameter int CAPACITY = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  ecsu_in_t                      in_data,
    input  logic                          load_ok,
    output logic                          take,
    output logic                          batch_valid,
    output ecsu_batch_t                   batch,
    output logic [$clog2(CAPACITY+1)-1:0] count_q
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 1;

    ecsu_mode_t      mode_reg, mode_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            err_reg, err_next;
    logic [2:0]      num;

    always_comb begin
        logic [7:0]    b;
        logic          last;
        logic [CW-1:0] c;
        logic [SW-1:0] sum;
        logic          e;
        logic          s_v;
        logic [7:0]    s_val;
        logic [7:0]    s_rep;
        logic          run;
        logic          four;
        logic          alive;
        logic [3:0]    code;
        logic          term;
        logic [7:0]    val;
        logic [31:0]   cwide;
        logic [1:0]    fin;

        b         = in_data.packed_byte;
        last      = in_data.stream_last;
        c         = cnt_reg;
        mode_next = mode_reg;
        e         = 1'b0;
        s_v       = 1'b0;
        s_val     = '0;
        s_rep     = '0;
        run       = 1'b0;
        four      = 1'b0;
        alive     = 1'b1;
        code      = '0;
        term      = 1'b0;
        val       = '0;
        num       = '0;
        batch     = '0;
        sum       = SW'(c) + SW'(b);
        cwide     = '0;
        fin       = '0;

        if (!err_reg) begin
            case (mode_reg)
                MODE_AFTER81: begin
                    mode_next = MODE_NORMAL;
                    if (b == 8'h00) begin
                        s_v   = 1'b1;
                        s_val = ESC_ZERO;
                        s_rep = 8'd1;
                    end else if (sum > SW'(CAPACITY)) begin
                        e = 1'b1;
                    end else begin
                        s_v   = 1'b1;
                        s_val = 8'h00;
                        s_rep = b;
                    end
                end
                MODE_AFTER82, MODE_AFTER84: begin
                    if (b == LIT_MARK) begin
                        s_v       = 1'b1;
                        s_val     = (mode_reg == MODE_AFTER82) ? ESC_RUN2 : ESC_RUN4;
                        s_rep     = 8'd1;
                        mode_next = MODE_NORMAL;
                    end else begin
                        run       = 1'b1;
                        four      = (mode_reg == MODE_AFTER84);
                        mode_next = four ? MODE_RUN4 : MODE_RUN2;
                    end
                end
                MODE_RUN2: begin
                    run = 1'b1;
                end
                MODE_RUN4: begin
                    run  = 1'b1;
                    four = 1'b1;
                end
                default: begin
                    mode_next = MODE_NORMAL;
                    if (c >= CW'(CAPACITY)) begin
                        e = 1'b1;
                    end else if (last) begin
                        s_v   = 1'b1;
                        s_val = b;
                        s_rep = 8'd1;
                    end else if (b == ESC_ZERO) begin
                        mode_next = MODE_AFTER81;
                    end else if (b == ESC_RUN2) begin
                        mode_next = MODE_AFTER82;
                    end else if (b == ESC_RUN4) begin
                        mode_next = MODE_AFTER84;
                    end else begin
                        s_v   = 1'b1;
                        s_val = b;
                        s_rep = 8'd1;
                    end
                end
            endcase

            if (s_v) begin
                c     = c + CW'(s_rep);
                cwide = 32'(c);
                batch[0].out_value    = s_val;
                batch[0].repeat_count = s_rep;
                batch[0].total_out    = cwide[TOTAL_W-1:0];
                num = 3'd1;
            end

            // Walk the codes of a run byte, most significant first.
            if (run) begin
                for (int k = 0; k < 4; k++) begin
                    if (alive && (k < 2 || !four)) begin
                        if (four) begin
                            code = (k == 0) ? b[7:4] : b[3:0];
                            term = (code == TERM4);
                            val  = code[3] ? {4'hF, code} : {4'h0, code};
                        end else begin
                            code = {2'b00, b[7-2*k -: 2]};
                            term = (code[1:0] == TERM2);
                            val  = (code[1:0] == 2'h3) ? 8'hFF : {6'b0, code[1:0]};
                        end
                        if (!term) begin
                            c     = c + CW'(1);
                            cwide = 32'(c);
                            batch[num[1:0]].out_value    = val;
                            batch[num[1:0]].repeat_count = 8'd1;
                            batch[num[1:0]].total_out    = cwide[TOTAL_W-1:0];
                            num = num + 3'd1;
                        end else begin
                            mode_next = MODE_NORMAL;
                            alive     = 1'b0;
                        end
                        if (c >= CW'(CAPACITY)) begin
                            e     = 1'b1;
                            alive = 1'b0;
                        end
                    end
                end
            end

            if (last && !e && (mode_next == MODE_RUN2 || mode_next == MODE_RUN4)) begin
                e = 1'b1;
            end
        end

        err_next = err_reg | e;
        cnt_next = c;

        // Notice when the byte must report but yields no data.
        if ((last || e) && num == 3'd0) begin
            cwide = 32'(c);
            batch[0].total_out = cwide[TOTAL_W-1:0];
            num = 3'd1;
        end
        if (num != 3'd0) begin
            fin = 2'(num - 3'd1);
            batch[fin].last_of_item = 1'b1;
            batch[fin].stream_done  = last;
            batch[fin].decode_error = (last || e) && err_next;
        end
    end

    assign batch_valid = in_valid && (num != 3'd0);
    assign take        = in_valid && ((num == 3'd0) || load_ok);
    assign count_q     = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (take) begin
            if (in_data.stream_last) begin
                mode_reg <= MODE_NORMAL;
                cnt_reg  <= '0;
                err_reg  <= 1'b0;
            end else begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

// File: src/ecsu_serial.sv
// Result register: holds one byte's batch and issues one result per cycle while m_ready is high.
// Depends on ecsu_pkg.
module ecsu_serial import ecsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        batch_valid,
    input  ecsu_batch_t batch,
    output logic        load_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output ecsu_res_t   m_data
);

    ecsu_batch_t slots_reg;
    logic [1:0]  idx_reg;
    logic        valid_reg;

    assign m_data  = slots_reg[idx_reg];
    assign m_valid = valid_reg;
    assign load_ok = !valid_reg || (m_ready && m_data.last_of_item);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load_ok) begin
            valid_reg <= batch_valid;
            idx_reg   <= '0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && batch_valid) begin
            slots_reg <= batch;
        end
    end

endmodule

// File: dv/ecsu_unpack_checker.sv
// Checker for the escape-coded spectrum unpacker: predicts the unpacked results of every
// input transaction and compares them, field by field, with the result transactions.
// Depends on ecsu_pkg for the payload types, the mode encoding and the escape codes.
module ecsu_unpack_checker import ecsu_pkg::*; #(
    parameter int CAPACITY = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  ecsu_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  ecsu_res_t m_data,
    output int        mismatch_count,
    output int        results_due,
    output int        results_checked
);

    // Decoder state as the block should hold it.
    ecsu_mode_t  mode_q;
    int unsigned count_q;
    bit          err_q;

    ecsu_res_t   byte_results[$];
    ecsu_res_t   unpacked_due[$];
    ecsu_res_t   want;

    task automatic add_result(input logic [7:0] val, input logic [7:0] rep);
        ecsu_res_t r;
        count_q          = count_q + rep;
        r                = '0;
        r.out_value      = val;
        r.repeat_count   = rep;
        r.total_out      = count_q[TOTAL_W-1:0];
        byte_results.push_back(r);
    endtask

    // Decode one byte of a 2-bit or 4-bit code run, most significant code first.
    task automatic decode_codes(input logic [7:0] b, input bit nibbles, output bit overrun);
        logic [3:0] code;
        bit         stop;
        bit         done;
        overrun = 1'b0;
        done    = 1'b0;
        for (int k = 0; k < (nibbles ? 2 : 4) && !done; k++) begin
            if (nibbles) begin
                code = b[(7 - 4 * k) -: 4];
                stop = (code == TERM4);
                if (!stop)
                    add_result(code < 4'd8 ? {4'h0, code} : {4'hF, code}, 8'd1);
            end else begin
                code = {2'b00, b[(7 - 2 * k) -: 2]};
                stop = (code[1:0] == TERM2);
                if (!stop)
                    add_result(code[1:0] == 2'd3 ? 8'hFF : {6'd0, code[1:0]}, 8'd1);
            end
            if (stop)
                mode_q = MODE_NORMAL;
            if (count_q >= CAPACITY) begin
                overrun = 1'b1;
                done    = 1'b1;
            end else if (stop) begin
                done = 1'b1;
            end
        end
    endtask

    // Work out the results of one packed byte and queue them.
    task automatic unpack_byte(input ecsu_in_t item);
        logic [7:0] b;
        bit         fin;
        bit         bad;
        ecsu_res_t  r;
        b   = item.packed_byte;
        fin = item.stream_last;
        bad = 1'b0;
        byte_results.delete();
        if (!err_q || fin) begin
            if (!err_q) begin
                case (mode_q)
                    MODE_AFTER81: begin
                        mode_q = MODE_NORMAL;
                        if (b == 8'd0)
                            add_result(ESC_ZERO, 8'd1);
                        else if (count_q + b > CAPACITY)
                            bad = 1'b1;
                        else
                            add_result(8'd0, b);
                    end
                    MODE_AFTER82, MODE_AFTER84: begin
                        if (b == LIT_MARK) begin
                            add_result(mode_q == MODE_AFTER82 ? ESC_RUN2 : ESC_RUN4, 8'd1);
                            mode_q = MODE_NORMAL;
                        end else begin
                            if (mode_q == MODE_AFTER82)
                                mode_q = MODE_RUN2;
                            else
                                mode_q = MODE_RUN4;
                            decode_codes(b, mode_q == MODE_RUN4, bad);
                        end
                    end
                    MODE_RUN2, MODE_RUN4: begin
                        decode_codes(b, mode_q == MODE_RUN4, bad);
                    end
                    default: begin
                        mode_q = MODE_NORMAL;
                        if (count_q >= CAPACITY)
                            bad = 1'b1;
                        else if (fin)
                            add_result(b, 8'd1);
                        else if (b == ESC_ZERO)
                            mode_q = MODE_AFTER81;
                        else if (b == ESC_RUN2)
                            mode_q = MODE_AFTER82;
                        else if (b == ESC_RUN4)
                            mode_q = MODE_AFTER84;
                        else
                            add_result(b, 8'd1);
                    end
                endcase
                if (fin && !bad && (mode_q == MODE_RUN2 || mode_q == MODE_RUN4))
                    bad = 1'b1;
                if (bad)
                    err_q = 1'b1;
            end
            if ((fin || bad) && byte_results.size() == 0)
                add_result(8'd0, 8'd0);
            if (byte_results.size() > 0) begin
                r              = byte_results.pop_back();
                r.last_of_item = 1'b1;
                r.stream_done  = fin;
                r.decode_error = (fin || bad) && err_q;
                byte_results.push_back(r);
            end
            foreach (byte_results[i])
                unpacked_due.push_back(byte_results[i]);
        end
        if (fin) begin
            mode_q  = MODE_NORMAL;
            count_q = 0;
            err_q   = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Retire results before taking new input: a result never belongs to a byte of the
    // same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q  = MODE_NORMAL;
            count_q = 0;
            err_q   = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (unpacked_due.size() == 0) begin
                    $error("result with nothing due: value %0d repeat %0d total %0d",
                           m_data.out_value, m_data.repeat_count, m_data.total_out);
                    mismatch_count++;
                end else begin
                    want = unpacked_due.pop_front();
                    check_field("out_value", 16'(want.out_value), 16'(m_data.out_value));
                    check_field("repeat_count", 16'(want.repeat_count),
                                16'(m_data.repeat_count));
                    check_field("last_of_item", 16'(want.last_of_item),
                                16'(m_data.last_of_item));
                    check_field("stream_done", 16'(want.stream_done),
                                16'(m_data.stream_done));
                    check_field("decode_error", 16'(want.decode_error),
                                16'(m_data.decode_error));
                    check_field("total_out", 16'(want.total_out), 16'(m_data.total_out));
                end
                results_checked++;
            end
            if (s_valid && s_ready)
                unpack_byte(s_data);
        end
        results_due = unpacked_due.size();
    end

endmodule

// File: dv/tb.sv
// Top of the unpacker testbench: clock, reset, byte-stream stimulus and the verdict.
// Depends on ecsu_pkg, escape_coded_spectrum_unpacker_unit and ecsu_unpack_checker.
module tb;
    import ecsu_pkg::*;

    localparam int CAPACITY    = 4096;
    // Longest stretch without any transaction before the run is declared hung. The
    // worst legal stretch is a long sender gap plus a long receiver stall, well under this.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 250;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ecsu_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    ecsu_res_t m_data;

    int        mismatch_count;
    int        results_due;
    int        results_checked;

    // Stimulus bookkeeping.
    logic [7:0] stream_q[$];
    bit         quiet;
    int         bytes_sent;
    int         streams_sent;
    int         full_streams;
    int         idle_cycles;

    escape_coded_spectrum_unpacker_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ecsu_unpack_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Pick an idle gap: mostly none or short, now and then long. Quiet streams run flat out.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Receiver: alternate random stalls with bursts of readiness. Drive at the falling
    // edge so the block samples a settled m_ready at the rising edge.
    initial begin
        int stall;
        int burst;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_gap();
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            burst = $urandom_range(8, 1);
            repeat (burst) begin
                @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    // Offer one byte after a random gap and hold it until the transaction completes.
    // Valid stays high across back-to-back bytes; only the payload changes.
    task automatic send_byte(input logic [7:0] b, input bit fin);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_data.packed_byte = b;
        s_data.stream_last = fin;
        do
            @(posedge aclk);
        while (!s_ready);
        bytes_sent++;
    endtask

    // Send the queued stream, marking its final byte.
    task automatic send_queued();
        foreach (stream_q[i])
            send_byte(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    // Lower valid and hold off until every result due has been taken.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_due != 0)
            @(negedge aclk);
    endtask

    // One byte of a code run; term_slot marks where the end code goes (-1 for none).
    // Non-terminating codes avoid the end code so the run carries on.
    function automatic logic [7:0] code_byte(input bit nibbles, input int term_slot);
        logic [7:0] b;
        int         c;
        b = '0;
        for (int k = 0; k < (nibbles ? 2 : 4); k++) begin
            if (nibbles) begin
                c = $urandom_range(14);
                if (c >= 8)
                    c++;
                if (k == term_slot)
                    c = TERM4;
                b[(7 - 4 * k) -: 4] = c[3:0];
            end else begin
                c = $urandom_range(2);
                if (c == 2)
                    c = 3;
                if (k == term_slot)
                    c = TERM2;
                b[(7 - 2 * k) -: 2] = c[1:0];
            end
        end
        return b;
    endfunction

    // Append one well-formed token with random content, or a noise byte.
    task automatic append_token();
        int         roll;
        int         nbody;
        logic [7:0] b;
        roll = $urandom_range(99);
        if (roll < 25) begin
            // Plain literal: keep clear of the escapes.
            do
                b = 8'($urandom_range(255));
            while (b == ESC_ZERO || b == ESC_RUN2 || b == ESC_RUN4);
            stream_q.push_back(b);
        end else if (roll < 45) begin
            stream_q.push_back(ESC_ZERO);
            stream_q.push_back($urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255, 1)));
        end else if (roll < 62) begin
            stream_q.push_back(ESC_RUN2);
            nbody = $urandom_range(3);
            repeat (nbody)
                stream_q.push_back(code_byte(1'b0, -1));
            stream_q.push_back(code_byte(1'b0, $urandom_range(3)));
        end else if (roll < 79) begin
            stream_q.push_back(ESC_RUN4);
            nbody = $urandom_range(3);
            repeat (nbody)
                stream_q.push_back(code_byte(1'b1, -1));
            stream_q.push_back(code_byte(1'b1, $urandom_range(1)));
        end else if (roll < 87) begin
            stream_q.push_back($urandom_range(1) ? ESC_RUN2 : ESC_RUN4);
            stream_q.push_back(LIT_MARK);
        end else begin
            stream_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // Build and send one random stream. A filled stream first runs the count up to just
    // below capacity with long zero runs, so the tokens after it hit the overrun cases.
    task automatic send_random_stream(input bit fill);
        int ntok;
        stream_q.delete();
        quiet = ($urandom_range(4) == 0);
        if (fill) begin
            repeat (16) begin
                stream_q.push_back(ESC_ZERO);
                stream_q.push_back(8'd255);
            end
            full_streams++;
        end
        ntok = fill ? $urandom_range(20, 6) : $urandom_range(10, 1);
        repeat (ntok)
            append_token();
        // Break the tail now and then, so the stream can end inside a run or after an escape.
        if ($urandom_range(6) == 0 && stream_q.size() > 1)
            void'(stream_q.pop_back());
        send_queued();
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data.packed_byte = '0;
        s_data.stream_last = 1'b0;
        quiet              = 1'b0;
        bytes_sent         = 0;
        streams_sent       = 0;
        full_streams       = 0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: value extremes, every escape and its literal form, runs ending at each nibble
        // position and at the last 2-bit position, and a final escape byte taken as a literal.
        stream_q = '{8'h00, 8'hFF, ESC_ZERO, 8'h00, ESC_ZERO, 8'h05, ESC_ZERO, 8'hFF,
                     ESC_RUN2, LIT_MARK, ESC_RUN4, LIT_MARK,
                     ESC_RUN2, 8'h1C, 8'h72,
                     ESC_RUN4, 8'h7F, 8'h9A, 8'h38,
                     ESC_RUN4, 8'h8F,
                     ESC_ZERO};
        send_queued();
        // Stream that ends inside a 2-bit run: flagged as an error.
        stream_q = '{ESC_RUN2, 8'h00};
        send_queued();
        // Stream that ends on the byte after an escape: decoded as usual.
        stream_q = '{ESC_RUN4, LIT_MARK};
        send_queued();
        // Single-byte stream made of an escape alone.
        stream_q = '{ESC_RUN2};
        send_queued();
        drain();

        // Random streams; the second is always filled to capacity. Hold off for the block
        // to empty after every filled stream and now and then besides.
        while (bytes_sent < RANDOM_BYTES) begin
            if (streams_sent == 5 || $urandom_range(5) == 0) begin
                send_random_stream(1'b1);
                drain();
            end else begin
                send_random_stream(1'b0);
                if ($urandom_range(7) == 0)
                    drain();
            end
        end

        drain();
        // Allow for any stray result still in flight.
        repeat (10) @(negedge aclk);

        $display("summary: %0d bytes in %0d streams, %0d run up to capacity",
                 bytes_sent, streams_sent, full_streams);
        $display("summary: %0d results checked, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
